// ===== src/quad_timer_compare_overflow_top_defines.svh =====
// ----------------------------------------------------------------------------
// Quad timer assertion macros
// Shared assertion forms for the quad timer checkers.
// ----------------------------------------------------------------------------
`ifndef QUAD_TIMER_COMPARE_OVERFLOW_TOP_DEFINES_SVH
`define QUAD_TIMER_COMPARE_OVERFLOW_TOP_DEFINES_SVH

// Concurrent check, muted while reset is asserted
`define QTCO_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also runs through reset
`define QTCO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/qtco_pkg.sv =====
// ----------------------------------------------------------------------------
// qtco_pkg
// Types and constants shared by the quad timer modules.
// ----------------------------------------------------------------------------
package qtco_pkg;

  // Timer count default
  localparam int NUM_TIMERS_DEF = 4;
  localparam int MAX_TIMERS     = 4;

  // Bus window
  localparam logic [31:0] WIN_LO = 32'h1000_0000;
  localparam logic [31:0] WIN_HI = 32'h1000_1830;

  // Opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register codes (offset bits 5:4)
  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_MODE  = 2'd1;
  localparam logic [1:0] REG_COMP  = 2'd2;
  localparam logic [1:0] REG_HOLD  = 2'd3;

  // Prescale select codes
  localparam logic [1:0] PRESC_1      = 2'd0;
  localparam logic [1:0] PRESC_16     = 2'd1;
  localparam logic [1:0] PRESC_256    = 2'd2;
  localparam logic [1:0] PRESC_HBLANK = 2'd3;

  // MODE layout
  localparam int MODE_W      = 10;
  localparam int BIT_ZRET    = 6;
  localparam int BIT_CUE     = 7;
  localparam int BIT_CMPE    = 8;
  localparam int BIT_OVFE    = 9;
  localparam int FLAG_EQ_BIT = 10;
  localparam int FLAG_OV_BIT = 11;

  // Configuration
  localparam logic [15:0] HBLANK_RESET   = 16'd9371;
  localparam logic        CFG_IDX_HBLANK = 1'b0;

  // Per-transaction command broadcast to every timer lane
  typedef struct packed {
    logic        fire;
    logic        tick;
    logic        wr;
    logic [1:0]  reg_code;
    logic [15:0] wdata;
  } qtco_cmd_t;

endpackage

// ===== src/qtco_cfg.sv =====
// ----------------------------------------------------------------------------
// qtco_cfg
// APB-style configuration register holding the hblank period.
// ----------------------------------------------------------------------------
module qtco_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] hblank_o
);
  import qtco_pkg::*;

  logic [15:0] hblank_q, hblank_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == CFG_IDX_HBLANK);

  // Write access
  always_comb begin
    hblank_d = hblank_q;
    if (wr_en) begin
      hblank_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hblank_q <= HBLANK_RESET;
    end else begin
      hblank_q <= hblank_d;
    end
  end

  // Read back
  assign prdata   = (paddr[2] == CFG_IDX_HBLANK) ? {16'd0, hblank_q} : 32'd0;
  assign hblank_o = hblank_q;

endmodule

// ===== src/qtco_timer.sv =====
// ----------------------------------------------------------------------------
// qtco_timer
// One 16-bit timer: prescaler, counter, compare, overflow and its registers.
// ----------------------------------------------------------------------------
module qtco_timer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qtco_pkg::qtco_cmd_t cmd_i,
  input  logic               hit_i,
  input  logic [15:0]        hblank_i,
  output logic [15:0]        rdata_o,
  output logic               irq_o
);
  import qtco_pkg::*;

  logic [15:0]       count_q, count_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [15:0]       comp_q, comp_d;
  logic [15:0]       hold_q, hold_d;
  logic              eq_q, eq_d;
  logic              ov_q, ov_d;
  logic [15:0]       phase_q, phase_d;

  logic [15:0] period;
  logic [15:0] phase_inc;
  logic [15:0] count_inc;
  logic        step;
  logic        cmp_hit;
  logic        wrap;
  logic        wr_en;

  // Prescale period
  always_comb begin
    case (mode_q[1:0])
      PRESC_1:      period = 16'd1;
      PRESC_16:     period = 16'd16;
      PRESC_256:    period = 16'd256;
      PRESC_HBLANK: period = (hblank_i == 16'd0) ? 16'd1 : hblank_i;
      default:      period = 16'd1;
    endcase
  end

  assign phase_inc = phase_q + 16'd1;
  assign count_inc = count_q + 16'd1;
  assign step      = (phase_inc >= period);
  assign cmp_hit   = (count_inc == comp_q);
  assign wrap      = (count_q == 16'hFFFF);
  assign wr_en     = cmd_i.fire & cmd_i.wr & hit_i;

  // Next state: tick advance or register write
  always_comb begin
    count_d = count_q;
    mode_d  = mode_q;
    comp_d  = comp_q;
    hold_d  = hold_q;
    eq_d    = eq_q;
    ov_d    = ov_q;
    phase_d = phase_q;
    irq_o   = 1'b0;
    if (cmd_i.tick && mode_q[BIT_CUE]) begin
      if (!step) begin
        phase_d = phase_inc;
      end else begin
        phase_d = 16'd0;
        count_d = count_inc;
        if (cmp_hit) begin
          if (mode_q[BIT_CMPE]) begin
            eq_d  = 1'b1;
            irq_o = 1'b1;
          end
          if (mode_q[BIT_ZRET]) begin
            count_d = 16'd0;
          end
        end
        if (wrap && mode_q[BIT_OVFE]) begin
          ov_d  = 1'b1;
          irq_o = 1'b1;
        end
      end
    end
    if (wr_en) begin
      case (cmd_i.reg_code)
        REG_COUNT: begin
          count_d = cmd_i.wdata;
          phase_d = 16'd0;
        end
        REG_MODE: begin
          mode_d  = cmd_i.wdata[MODE_W-1:0];
          phase_d = 16'd0;
          if (cmd_i.wdata[FLAG_EQ_BIT]) begin
            eq_d = 1'b0;
          end
          if (cmd_i.wdata[FLAG_OV_BIT]) begin
            ov_d = 1'b0;
          end
        end
        REG_COMP: comp_d = cmd_i.wdata;
        REG_HOLD: hold_d = cmd_i.wdata;
        default: ;
      endcase
    end
  end

  // State commits only when the transaction is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mode_q  <= '0;
      comp_q  <= '0;
      hold_q  <= '0;
      eq_q    <= 1'b0;
      ov_q    <= 1'b0;
      phase_q <= '0;
    end else if (cmd_i.fire) begin
      count_q <= count_d;
      mode_q  <= mode_d;
      comp_q  <= comp_d;
      hold_q  <= hold_d;
      eq_q    <= eq_d;
      ov_q    <= ov_d;
      phase_q <= phase_d;
    end
  end

  // Read mux, zero unless this lane is addressed
  always_comb begin
    rdata_o = 16'd0;
    if (hit_i) begin
      case (cmd_i.reg_code)
        REG_COUNT: rdata_o = count_q;
        REG_MODE:  rdata_o = {4'd0, ov_q, eq_q, mode_q};
        REG_COMP:  rdata_o = comp_q;
        REG_HOLD:  rdata_o = hold_q;
        default:   rdata_o = 16'd0;
      endcase
    end
  end

endmodule

// ===== src/quad_timer_compare_overflow_top.sv =====
// ----------------------------------------------------------------------------
// quad_timer_compare_overflow_top
// Four timers with compare and overflow behind a transaction channel.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register.
// Throughput: 1 transaction per cycle while the result is not stalled; decode,
//   timer update and read mux sit in one combinational pass between the input and
//   result registers. Reset: asynchronous, active low; timers and flags clear,
//   hblank = 9371, both pipeline stages empty. Accepts transactions right after reset.
module quad_timer_compare_overflow_top #(
  parameter int NUM_TIMERS = qtco_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] address_i,
  input  logic [15:0] write_data_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        handled_o,
  output logic [15:0] read_data_o,
  output logic [3:0]  irq_lines_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qtco_pkg::*;

  // Input stage
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_op_q;
  logic [31:0] s1_addr_q;
  logic [15:0] s1_wdata_q;

  // Result stage
  logic        out_valid_q, out_valid_d;
  logic        handled_q, handled_d;
  logic [15:0] rdata_q, rdata_d;
  logic [3:0]  irq_q, irq_d;

  logic        in_accept;
  logic        adv;
  logic [15:0] hblank;

  // Decode
  logic [31:0] off;
  logic        in_win;
  logic        reg_ok;
  logic [1:0]  idx;
  logic        idx_ok;
  logic        hit_any;
  logic        is_tick, is_read, is_write;

  qtco_cmd_t   cmd;
  logic [15:0] lane_rdata [MAX_TIMERS];
  logic [3:0]  lane_irq;
  logic [15:0] rdata_or;

  // Handshake
  assign adv        = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~adv;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= opcode_i;
      s1_addr_q  <= address_i;
      s1_wdata_q <= write_data_i;
    end
  end

  // Address decode
  assign off     = s1_addr_q - WIN_LO;
  assign in_win  = (s1_addr_q >= WIN_LO) && (s1_addr_q <= WIN_HI);
  assign idx     = off[12:11];
  assign reg_ok  = (off[10:6] == 5'd0) && (off[3:0] == 4'd0);
  assign idx_ok  = ({1'b0, idx} < 3'(NUM_TIMERS));
  assign hit_any = in_win & reg_ok & idx_ok;

  assign is_tick  = (s1_op_q == OP_TICK);
  assign is_read  = (s1_op_q == OP_READ);
  assign is_write = (s1_op_q == OP_WRITE);

  assign cmd.fire     = adv;
  assign cmd.tick     = is_tick;
  assign cmd.wr       = is_write;
  assign cmd.reg_code = off[5:4];
  assign cmd.wdata    = s1_wdata_q;

  // Configuration register
  qtco_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .hblank_o (hblank)
  );

  // Timer lanes
  for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_lane
    if (g < NUM_TIMERS) begin : g_on
      qtco_timer u_timer (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .cmd_i    (cmd),
        .hit_i    (hit_any && (idx == 2'(g))),
        .hblank_i (hblank),
        .rdata_o  (lane_rdata[g]),
        .irq_o    (lane_irq[g])
      );
    end else begin : g_off
      assign lane_rdata[g] = 16'd0;
      assign lane_irq[g]   = 1'b0;
    end
  end

  // Read data merge, only the addressed lane is nonzero
  always_comb begin
    rdata_or = 16'd0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      rdata_or = rdata_or | lane_rdata[i];
    end
  end

  // Result fields
  always_comb begin
    handled_d = 1'b0;
    rdata_d   = 16'd0;
    irq_d     = 4'd0;
    if (is_tick) begin
      handled_d = 1'b1;
      irq_d     = lane_irq;
    end else if (is_read) begin
      handled_d = hit_any;
      rdata_d   = rdata_or;
    end else if (is_write) begin
      handled_d = hit_any;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      handled_q <= handled_d;
      rdata_q   <= rdata_d;
      irq_q     <= irq_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign handled_o   = handled_q;
  assign read_data_o = rdata_q;
  assign irq_lines_o = irq_q;

endmodule

// ===== src/qtco_checker.sv =====
// ----------------------------------------------------------------------------
// qtco_checker
// Port-level checks for the quad timer, bound to the top level.
// ----------------------------------------------------------------------------
`include "quad_timer_compare_overflow_top_defines.svh"

module qtco_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        handled_o,
  input logic [15:0] read_data_o,
  input logic [3:0]  irq_lines_o
);

  // A held result keeps its fields
  `QTCO_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(handled_o) && $stable(read_data_o) && $stable(irq_lines_o)), "stalled result changed")

  // Input only backs up when a result is waiting
  `QTCO_ASSERT(a_stall_needs_out, clk_i, rst_ni, in_stall_o |-> out_valid_o, "input stalled with empty result stage")

  // Interrupts only come from ticks, which are handled and read zero
  `QTCO_ASSERT(a_irq_tick, clk_i, rst_ni, (out_valid_o && (irq_lines_o != 4'd0)) |-> (handled_o && (read_data_o == 16'd0)), "interrupt on a non-tick result")

  // An accepted transaction into an empty result stage reaches the output through the input and result registers
  `QTCO_ASSERT(a_latency, clk_i, rst_ni, (in_valid_i && !in_stall_o && !out_valid_o) |=> ##1 out_valid_o, "result missing after accept")

  // Nothing is presented right out of reset
  `QTCO_ASSERT_ALWAYS(a_reset_empty, clk_i, $rose(rst_ni) |-> !out_valid_o, "result valid out of reset")

endmodule

bind quad_timer_compare_overflow_top qtco_checker u_qtco_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .handled_o   (handled_o),
  .read_data_o (read_data_o),
  .irq_lines_o (irq_lines_o)
);

// ===== tb/quad_timer_compare_overflow_checker.sv =====
// ----------------------------------------------------------------------------
// Quad timer response checker
// Watches the input, output and configuration channels of the quad timer.
// Keeps its own copy of the timer state, predicts the response of every
// accepted transaction and compares each accepted response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_timer_compare_overflow_checker #(
  parameter int NUM_TIMERS = qtco_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] address_i,
  input  logic [15:0] write_data_i,
  // Output channel
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        handled_i,
  input  logic [15:0] read_data_i,
  input  logic [3:0]  irq_lines_i,
  // Configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  // Status to the testbench top
  output int          error_count_o,
  output int          pending_count_o
);
  import qtco_pkg::*;

  typedef struct packed {
    logic        handled;
    logic [15:0] read_data;
    logic [3:0]  irq_lines;
  } timer_resp_t;

  // Offset bits that must be zero for a register hit (only bits 5:4 may vary)
  localparam logic [31:0] REG_OFFSET_MASK = 32'h0000_07CF;
  localparam int          TIMER_SHIFT     = 11;

  // Shadow timer state
  logic [15:0]       count_q    [MAX_TIMERS];
  logic [MODE_W-1:0] mode_q     [MAX_TIMERS];
  logic [15:0]       compare_q  [MAX_TIMERS];
  logic [15:0]       hold_q     [MAX_TIMERS];
  logic              equal_q    [MAX_TIMERS];
  logic              overflow_q [MAX_TIMERS];
  logic [15:0]       phase_q    [MAX_TIMERS];
  logic [15:0]       hblank_q;

  timer_resp_t pending_responses[$];

  // Tick transactions per count step for a given MODE
  function automatic int unsigned count_period(input logic [MODE_W-1:0] mode);
    case (mode[1:0])
      PRESC_1:   return 1;
      PRESC_16:  return 16;
      PRESC_256: return 256;
      default:   return (hblank_q == 16'd0) ? 1 : 32'(hblank_q);  // hblank
    endcase
  endfunction

  // Timer index of a register address, or -1 when nothing is there
  function automatic int decode_address(input logic [31:0] addr, output logic [1:0] code);
    logic [31:0] offset;
    int          idx;
    code = REG_COUNT;
    if (addr < WIN_LO || addr > WIN_HI) return -1;
    offset = addr - WIN_LO;
    idx    = int'(offset >> TIMER_SHIFT);
    if (idx >= NUM_TIMERS) return -1;
    if ((offset & REG_OFFSET_MASK) != 32'd0) return -1;
    code = offset[5:4];
    return idx;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count_o++;
  endtask

  // Apply one transaction to the shadow state and return its response
  task automatic predict_timer_response(input logic [1:0] op, input logic [31:0] addr,
                                        input logic [15:0] wdata, output timer_resp_t resp);
    int          idx;
    logic [1:0]  code;
    logic [15:0] old_count;
    logic [15:0] new_count;
    resp = '0;
    case (op)
      OP_TICK: begin
        resp.handled = 1'b1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (mode_q[i][BIT_CUE]) begin
            phase_q[i] = phase_q[i] + 16'd1;
            if (32'(phase_q[i]) >= count_period(mode_q[i])) begin
              phase_q[i] = '0;
              old_count  = count_q[i];
              new_count  = old_count + 16'd1;
              count_q[i] = new_count;
              // compare hit
              if (new_count == compare_q[i]) begin
                if (mode_q[i][BIT_CMPE]) begin
                  equal_q[i]        = 1'b1;
                  resp.irq_lines[i] = 1'b1;
                end
                if (mode_q[i][BIT_ZRET]) count_q[i] = '0;
              end
              // wrap out of 0xFFFF
              if (old_count == 16'hFFFF && mode_q[i][BIT_OVFE]) begin
                overflow_q[i]     = 1'b1;
                resp.irq_lines[i] = 1'b1;
              end
            end
          end
        end
      end
      OP_READ: begin
        idx = decode_address(addr, code);
        if (idx >= 0) begin
          resp.handled = 1'b1;
          case (code)
            REG_COUNT: resp.read_data = count_q[idx];
            REG_MODE:  resp.read_data = {4'b0, overflow_q[idx], equal_q[idx], mode_q[idx]};
            REG_COMP:  resp.read_data = compare_q[idx];
            default:   resp.read_data = hold_q[idx];
          endcase
        end
      end
      OP_WRITE: begin
        idx = decode_address(addr, code);
        if (idx >= 0) begin
          resp.handled = 1'b1;
          case (code)
            REG_COUNT: begin
              count_q[idx] = wdata;
              phase_q[idx] = '0;
            end
            REG_MODE: begin
              // write-1-clear flags; count is kept
              if (wdata[FLAG_EQ_BIT]) equal_q[idx] = 1'b0;
              if (wdata[FLAG_OV_BIT]) overflow_q[idx] = 1'b0;
              mode_q[idx]  = wdata[MODE_W-1:0];
              phase_q[idx] = '0;
            end
            REG_COMP: compare_q[idx] = wdata;
            default:  hold_q[idx] = wdata;
          endcase
        end
      end
      default: ;  // unused opcode: no effect, all-zero response
    endcase
  endtask

  // Channel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    timer_resp_t got;
    timer_resp_t exp;
    timer_resp_t pred;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TIMERS; i++) begin
        count_q[i]    = '0;
        mode_q[i]     = '0;
        compare_q[i]  = '0;
        hold_q[i]     = '0;
        equal_q[i]    = 1'b0;
        overflow_q[i] = 1'b0;
        phase_q[i]    = '0;
      end
      hblank_q = HBLANK_RESET;
      pending_responses.delete();
    end else begin
      // configuration write
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == {CFG_IDX_HBLANK, 2'b00})
        hblank_q = pwdata_i[15:0];

      // response side
      if (out_valid_i && !out_stall_i) begin
        got = '{handled: handled_i, read_data: read_data_i, irq_lines: irq_lines_i};
        if (pending_responses.size() == 0) begin
          report_mismatch("response with no transaction outstanding");
        end else begin
          exp = pending_responses.pop_front();
          if (got.handled !== exp.handled)
            report_mismatch($sformatf("handled: got %0b, expected %0b",
                                      got.handled, exp.handled));
          if (got.read_data !== exp.read_data)
            report_mismatch($sformatf("read_data: got 0x%04h, expected 0x%04h",
                                      got.read_data, exp.read_data));
          if (got.irq_lines !== exp.irq_lines)
            report_mismatch($sformatf("irq_lines: got 0x%0h, expected 0x%0h",
                                      got.irq_lines, exp.irq_lines));
        end
      end

      // request side
      if (in_valid_i && !in_stall_i) begin
        predict_timer_response(opcode_i, address_i, write_data_i, pred);
        pending_responses.push_back(pred);
      end
    end
    pending_count_o = pending_responses.size();
  end

endmodule

// ===== tb/quad_timer_compare_overflow_top_tb.sv =====
// ----------------------------------------------------------------------------
// Quad timer testbench top
// Drives directed and random bus transactions and tick transactions into the
// quad timer, steps the hblank period through several settings between
// phases, stalls the response side at random and reports the verdict from
// the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_timer_compare_overflow_top_tb;
  import qtco_pkg::*;

  localparam int          N_TIMERS        = NUM_TIMERS_DEF;
  localparam logic [1:0]  OP_UNUSED       = 2'd3;
  localparam logic [31:0] TIMER_STRIDE    = 32'h0000_0800;
  localparam int          NUM_PHASES      = 7;
  localparam int          QUIET_PHASE     = 3;
  localparam int          ITEMS_PER_PHASE = 245;
  localparam int          WATCHDOG_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES    = 4;

  localparam logic [15:0] MODE_ZRET  = 16'h1 << BIT_ZRET;
  localparam logic [15:0] MODE_CUE   = 16'h1 << BIT_CUE;
  localparam logic [15:0] MODE_CMPE  = 16'h1 << BIT_CMPE;
  localparam logic [15:0] MODE_OVFE  = 16'h1 << BIT_OVFE;
  localparam logic [15:0] FLAG_CLEAR = (16'h1 << FLAG_EQ_BIT) | (16'h1 << FLAG_OV_BIT);

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i     = OP_TICK;
  logic [31:0] address_i    = '0;
  logic [15:0] write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        handled_o;
  logic [15:0] read_data_o;
  logic [3:0]  irq_lines_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  logic quiet_q      = 1'b0;
  int   items_sent   = 0;
  int   idle_cycles  = 0;
  int   error_count;
  int   pending_count;

  quad_timer_compare_overflow_top #(
    .NUM_TIMERS(N_TIMERS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .address_i   (address_i),
    .write_data_i(write_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .handled_o   (handled_o),
    .read_data_o (read_data_o),
    .irq_lines_o (irq_lines_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  quad_timer_compare_overflow_checker #(
    .NUM_TIMERS(N_TIMERS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .opcode_i       (opcode_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .handled_i      (handled_o),
    .read_data_i    (read_data_o),
    .irq_lines_i    (irq_lines_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .error_count_o  (error_count),
    .pending_count_o(pending_count)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Random response-side back pressure
  always @(posedge clk_i) begin
    out_stall_i <= !quiet_q && rst_ni && ($urandom_range(99) < 7);
  end

  // Watchdog: cycles without any accepted transaction, response or configuration access
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] reg_address(input int t, input logic [1:0] code);
    return WIN_LO + 32'(t) * TIMER_STRIDE + {26'd0, code, 4'h0};
  endfunction

  // Addresses around and inside the register window
  function automatic logic [31:0] noise_address();
    case ($urandom_range(5))
      0:       return reg_address($urandom_range(N_TIMERS - 1), 2'($urandom_range(3)));
      1:       return WIN_LO + 32'($urandom_range(32'h1830));
      2:       return $urandom;
      3:       return WIN_LO - 32'd1;
      4:       return WIN_HI + 32'($urandom_range(1, 4));
      default: return reg_address($urandom_range(N_TIMERS - 1), 2'($urandom_range(3)))
                      + 32'($urandom_range(1, 15));
    endcase
  endfunction

  // One transaction on the input channel, with random idle gaps in front
  task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                           input logic [15:0] wdata);
    logic stalled;
    while (!quiet_q && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    write_data_i <= wdata;
    // stall only changes at the rising edge, so the mid-cycle value is the
    // one seen at the next edge
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    items_sent++;
  endtask

  // APB write of the hblank period: setup then access
  task automatic write_hblank(input logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_IDX_HBLANK, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    int          phase_start;
    int          roll;
    int          t;
    logic [15:0] cmp;
    logic [15:0] cnt;
    logic [15:0] mode_word;
    logic [15:0] hv;
    logic [1:0]  presc;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        // drain, let the pipeline settle, then retune the hblank period
        @(negedge clk_i);
        while (pending_count != 0) @(negedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
        case (ph)
          1:       hv = 16'd1;
          2:       hv = 16'd0;       // zero period counts like one
          3:       hv = 16'hFFFF;
          4:       hv = 16'd2;
          5:       hv = 16'($urandom_range(3, 24));
          default: hv = 16'd3;
        endcase
        write_hblank(hv);
      end
      quiet_q <= (ph == QUIET_PHASE);

      if (ph == 0) begin
        // reset values, hold at the top of the window
        send_item(OP_READ, reg_address(0, REG_COUNT), 16'h0000);
        send_item(OP_READ, reg_address(0, REG_MODE), 16'hFFFF);
        send_item(OP_WRITE, reg_address(3, REG_HOLD), 16'hFFFF);
        send_item(OP_READ, reg_address(3, REG_HOLD), 16'h0000);
        // compare hit with interrupt and return to zero
        send_item(OP_WRITE, reg_address(0, REG_COMP), 16'h0002);
        send_item(OP_WRITE, reg_address(0, REG_MODE), MODE_CUE | MODE_CMPE | MODE_ZRET);
        send_item(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_TICK, 32'h0000_0000, 16'h0000);
        send_item(OP_READ, reg_address(0, REG_MODE), 16'h0000);
        // wrap from 0xFFFF with overflow interrupt
        send_item(OP_WRITE, reg_address(1, REG_COUNT), 16'hFFFF);
        send_item(OP_WRITE, reg_address(1, REG_MODE), MODE_CUE | MODE_OVFE);
        send_item(OP_TICK, 32'h0000_0000, 16'h0000);
        send_item(OP_READ, reg_address(1, REG_MODE), 16'h0000);
        // flag clear with the upper bits set
        send_item(OP_WRITE, reg_address(1, REG_MODE), 16'hF000 | FLAG_CLEAR | MODE_CUE);
        send_item(OP_READ, reg_address(1, REG_MODE), 16'h0000);
        send_item(OP_WRITE, reg_address(2, REG_MODE), 16'hFFFF);
        send_item(OP_READ, reg_address(2, REG_MODE), 16'h0000);
        // unknown accesses and the unused opcode
        send_item(OP_READ, WIN_LO + 32'd4, 16'h0000);
        send_item(OP_READ, WIN_LO - 32'd1, 16'h0000);
        send_item(OP_WRITE, WIN_HI + 32'd4, 16'hFFFF);
        send_item(OP_READ, 32'hFFFF_FFFF, 16'h0000);
        send_item(OP_UNUSED, reg_address(0, REG_COUNT), 16'hFFFF);
        send_item(OP_TICK, WIN_LO, 16'h0000);
        send_item(OP_WRITE, reg_address(0, REG_MODE), 16'h0000);
        send_item(OP_READ, reg_address(0, REG_COUNT), 16'h0000);
      end

      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 75) begin
          // program one timer near an event, then let it run
          t   = $urandom_range(N_TIMERS - 1);
          cmp = 16'($urandom);
          if ($urandom_range(7) == 0) cmp = 16'h0000;
          case ($urandom_range(3))
            0:       cnt = cmp - 16'($urandom_range(1, 12));
            1:       cnt = 16'hFFFF - 16'($urandom_range(0, 12));
            2:       cnt = 16'($urandom);
            default: cnt = cmp;
          endcase
          roll  = $urandom_range(99);
          presc = (roll < 55) ? PRESC_1 : (roll < 70) ? PRESC_16 :
                  (roll < 80) ? PRESC_256 : PRESC_HBLANK;
          mode_word          = 16'($urandom);
          mode_word[1:0]     = presc;
          mode_word[BIT_CUE] = ($urandom_range(9) != 0);
          send_item(OP_WRITE, reg_address(t, REG_COMP), cmp);
          if ($urandom_range(1) == 1) begin
            send_item(OP_WRITE, reg_address(t, REG_COUNT), cnt);
            send_item(OP_WRITE, reg_address(t, REG_MODE), mode_word);
          end else begin
            send_item(OP_WRITE, reg_address(t, REG_MODE), mode_word);
            send_item(OP_WRITE, reg_address(t, REG_COUNT), cnt);
          end
          if ($urandom_range(3) == 0)
            send_item(OP_WRITE, reg_address(t, REG_HOLD), 16'($urandom));
          repeat ($urandom_range(4, 40)) begin
            if ($urandom_range(9) == 0)
              send_item(OP_READ, reg_address($urandom_range(N_TIMERS - 1),
                        2'($urandom_range(3))), 16'($urandom));
            else
              send_item(OP_TICK, $urandom, 16'($urandom));
          end
          send_item(OP_READ, reg_address(t, REG_MODE), 16'($urandom));
          send_item(OP_READ, reg_address(t, REG_COUNT), 16'($urandom));
          if ($urandom_range(1) == 1)
            send_item(OP_WRITE, reg_address(t, REG_MODE), mode_word | FLAG_CLEAR);
        end else begin
          // loose transactions of any kind
          repeat (6) send_item(2'($urandom_range(3)), noise_address(), 16'($urandom));
        end
      end
      in_valid_i <= 1'b0;
    end

    // wait for the last responses, then let the pipeline settle
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
